// File: rtl/gwl_pkg.sv
package gwl_pkg;

  localparam int DEF_MAX_KERNEL_DIM   = 15;
  localparam int DEF_MAX_GROUPS       = 1024;
  localparam int DEF_MAX_CH_PER_GROUP = 64;

  localparam int IDX_W      = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int NUM_STEPS  = 5;
  localparam int STEP_W     = $clog2(NUM_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_PER_GROUP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_PER_GROUP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSED_SOURCE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PACK_DIRECTION    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTIMIZED_LAYOUT  = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic accept;
    logic step_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic step_last;
  } status_t;

endpackage

// File: rtl/gconv_weight_layout_address_gen.sv
// channel | signals                                   | direction
// cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in (cfg_ready always high)
// in      | in_valid in_ready restart                 | in
// out     | out_valid out_ready src_index dst_index last | out
//
// An input beat runs through accept, 5 multiply-add steps on three shared
// lanes (one multiplier each), then a load into the result register.
// Synchronous reset loads the register defaults and clears the walk counters.
// The result register holds one beat; a new input is taken while it waits.
// If it is still full when the next result is done, that result holds.
module gconv_weight_layout_address_gen #(
  parameter int MAX_KERNEL_DIM   = gwl_pkg::DEF_MAX_KERNEL_DIM,
  parameter int MAX_GROUPS       = gwl_pkg::DEF_MAX_GROUPS,
  parameter int MAX_CH_PER_GROUP = gwl_pkg::DEF_MAX_CH_PER_GROUP
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gwl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gwl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gwl_pkg::IDX_W-1:0]      src_index,
  output logic [gwl_pkg::IDX_W-1:0]      dst_index,
  output logic                           last
);
  import gwl_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  gwl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gwl_dp #(
    .MAX_KERNEL_DIM   (MAX_KERNEL_DIM),
    .MAX_GROUPS       (MAX_GROUPS),
    .MAX_CH_PER_GROUP (MAX_CH_PER_GROUP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .cmd       (cmd),
    .status    (status),
    .src_index (src_index),
    .dst_index (dst_index),
    .last      (last)
  );

endmodule

// File: rtl/gwl_ctrl.sv
module gwl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  gwl_pkg::status_t status,
  output gwl_pkg::cmd_t    cmd
);
  import gwl_pkg::*;

  state_t state, state_next;
  logic   out_space;

  assign out_space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CALC;
      ST_CALC:  if (status.step_last) state_next = ST_WRITE;
      ST_WRITE: if (out_space) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.step_en  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CALC:  cmd.step_en = 1'b1;
      ST_WRITE: cmd.load_out = out_space;
      default: ;
    endcase
  end

  // result register flag; a load wins over a take in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/gwl_dp.sv
module gwl_dp #(
  parameter int MAX_KERNEL_DIM   = gwl_pkg::DEF_MAX_KERNEL_DIM,
  parameter int MAX_GROUPS       = gwl_pkg::DEF_MAX_GROUPS,
  parameter int MAX_CH_PER_GROUP = gwl_pkg::DEF_MAX_CH_PER_GROUP
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gwl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gwl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           restart,
  input  gwl_pkg::cmd_t                  cmd,
  output gwl_pkg::status_t               status,
  output logic [gwl_pkg::IDX_W-1:0]      src_index,
  output logic [gwl_pkg::IDX_W-1:0]      dst_index,
  output logic                           last
);
  import gwl_pkg::*;

  localparam int RD_W = $clog2(MAX_KERNEL_DIM + 1);
  localparam int GD_W = $clog2(MAX_GROUPS + 1);
  localparam int CD_W = $clog2(MAX_CH_PER_GROUP + 1);
  localparam int RC_W = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
  localparam int GC_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CC_W = (MAX_CH_PER_GROUP > 1) ? $clog2(MAX_CH_PER_GROUP) : 1;
  localparam int DW   = (GD_W > CD_W) ? ((GD_W > RD_W) ? GD_W : RD_W)
                                      : ((CD_W > RD_W) ? CD_W : RD_W);

  logic [3:0] kernel_rows, kernel_cols;
  logic [10:0] group_count;
  logic [6:0] in_per_group, out_per_group;
  logic transposed_source, pack_direction, optimized_layout;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_rows       <= 4'd3;
      kernel_cols       <= 4'd3;
      group_count       <= 11'd32;
      in_per_group      <= 7'd4;
      out_per_group     <= 7'd4;
      transposed_source <= 1'b0;
      pack_direction    <= 1'b1;
      optimized_layout  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_ROWS:       kernel_rows       <= cfg_data[3:0];
        CFG_KERNEL_COLS:       kernel_cols       <= cfg_data[3:0];
        CFG_GROUP_COUNT:       group_count       <= cfg_data[10:0];
        CFG_IN_PER_GROUP:      in_per_group      <= cfg_data[6:0];
        CFG_OUT_PER_GROUP:     out_per_group     <= cfg_data[6:0];
        CFG_TRANSPOSED_SOURCE: transposed_source <= cfg_data[0];
        CFG_PACK_DIRECTION:    pack_direction    <= cfg_data[0];
        CFG_OPTIMIZED_LAYOUT:  optimized_layout  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  logic [RD_W-1:0] eff_r, eff_s;
  logic [GD_W-1:0] eff_g;
  logic [CD_W-1:0] eff_c, eff_k;
  logic            quad4;

  assign eff_r = (kernel_rows == 4'd0) ? RD_W'(1) :
                 (32'(kernel_rows) > MAX_KERNEL_DIM) ? RD_W'(MAX_KERNEL_DIM) : RD_W'(kernel_rows);
  assign eff_s = (kernel_cols == 4'd0) ? RD_W'(1) :
                 (32'(kernel_cols) > MAX_KERNEL_DIM) ? RD_W'(MAX_KERNEL_DIM) : RD_W'(kernel_cols);
  assign eff_g = (group_count == 11'd0) ? GD_W'(1) :
                 (32'(group_count) > MAX_GROUPS) ? GD_W'(MAX_GROUPS) : GD_W'(group_count);
  assign eff_c = (in_per_group == 7'd0) ? CD_W'(1) :
                 (32'(in_per_group) > MAX_CH_PER_GROUP) ? CD_W'(MAX_CH_PER_GROUP)
                                                         : CD_W'(in_per_group);
  assign eff_k = (out_per_group == 7'd0) ? CD_W'(1) :
                 (32'(out_per_group) > MAX_CH_PER_GROUP) ? CD_W'(MAX_CH_PER_GROUP)
                                                          : CD_W'(out_per_group);
  assign quad4 = (32'(eff_c) == 4);

  // walk counters
  logic [RC_W-1:0] row_count, col_count, pos_r, pos_s;
  logic [CC_W-1:0] outch_count, inch_count, pos_k, pos_c;
  logic [GC_W-1:0] group_ctr, pos_g;
  logic            wrap_r, wrap_s, wrap_k, wrap_g, wrap_c;

  assign pos_r = restart ? '0 : row_count;
  assign pos_s = restart ? '0 : col_count;
  assign pos_k = restart ? '0 : outch_count;
  assign pos_g = restart ? '0 : group_ctr;
  assign pos_c = restart ? '0 : inch_count;

  assign wrap_r = (32'(pos_r) + 32'd1) >= 32'(eff_r);
  assign wrap_s = (32'(pos_s) + 32'd1) >= 32'(eff_s);
  assign wrap_k = (32'(pos_k) + 32'd1) >= 32'(eff_k);
  assign wrap_g = (32'(pos_g) + 32'd1) >= 32'(eff_g);
  assign wrap_c = (32'(pos_c) + 32'd1) >= 32'(eff_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      col_count   <= '0;
      outch_count <= '0;
      group_ctr   <= '0;
      inch_count  <= '0;
    end else if (cmd.accept) begin
      inch_count  <= wrap_c ? '0 : pos_c + 1'b1;
      group_ctr   <= !wrap_c ? pos_g : (wrap_g ? '0 : pos_g + 1'b1);
      outch_count <= !(wrap_c && wrap_g) ? pos_k : (wrap_k ? '0 : pos_k + 1'b1);
      col_count   <= !(wrap_c && wrap_g && wrap_k) ? pos_s : (wrap_s ? '0 : pos_s + 1'b1);
      row_count   <= !(wrap_c && wrap_g && wrap_k && wrap_s) ? pos_r
                                                              : (wrap_r ? '0 : pos_r + 1'b1);
    end
  end

  // latched position and multiply-accumulate lanes (u0, u1, packed)
  logic [IDX_W-1:0]  lr, ls, lk, lg, lc;
  logic              llast;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  acc0, acc1, acc2;
  logic [DW-1:0]     mul0 [NUM_STEPS];
  logic [DW-1:0]     mul1 [NUM_STEPS];
  logic [DW-1:0]     mul2 [NUM_STEPS];
  logic [IDX_W-1:0]  add0 [NUM_STEPS];
  logic [IDX_W-1:0]  add1 [NUM_STEPS];
  logic [IDX_W-1:0]  add2 [NUM_STEPS];
  logic [IDX_W-1:0]  prod0, prod1, prod2;

  assign status.step_last = (32'(step) == NUM_STEPS - 1);

  always_comb begin
    mul0[0] = DW'(eff_r); add0[0] = lr;
    mul0[1] = DW'(eff_s); add0[1] = ls;
    mul0[2] = DW'(eff_c); add0[2] = lc;
    mul0[3] = DW'(eff_k); add0[3] = lk;
    mul0[4] = DW'(1);     add0[4] = '0;

    mul1[0] = DW'(eff_k); add1[0] = lk;
    mul1[1] = DW'(eff_r); add1[1] = lr;
    mul1[2] = DW'(eff_s); add1[2] = ls;
    mul1[3] = DW'(eff_c); add1[3] = lc;
    mul1[4] = DW'(1);     add1[4] = '0;

    if (quad4) begin
      mul2[0] = DW'(eff_r); add2[0] = lr;
      mul2[1] = DW'(eff_s); add2[1] = ls;
      mul2[2] = DW'(eff_k); add2[2] = lk;
      mul2[3] = DW'(2);     add2[3] = IDX_W'(lg[0]);
      mul2[4] = DW'(eff_c); add2[4] = lc;
    end else begin
      mul2[0] = DW'(eff_c >> 2); add2[0] = lc >> 2;
      mul2[1] = DW'(eff_r);      add2[1] = lr;
      mul2[2] = DW'(eff_s);      add2[2] = ls;
      mul2[3] = DW'(eff_k);      add2[3] = lk;
      mul2[4] = DW'(4);          add2[4] = IDX_W'(lc[1:0]);
    end
  end

  // products kept modulo the index width
  assign prod0 = acc0 * IDX_W'(mul0[step]);
  assign prod1 = acc1 * IDX_W'(mul1[step]);
  assign prod2 = acc2 * IDX_W'(mul2[step]);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lr    <= IDX_W'(pos_r);
      ls    <= IDX_W'(pos_s);
      lk    <= IDX_W'(pos_k);
      lg    <= IDX_W'(pos_g);
      lc    <= IDX_W'(pos_c);
      llast <= wrap_c && wrap_g && wrap_k && wrap_s && wrap_r;
      acc0  <= IDX_W'(pos_g);
      acc1  <= IDX_W'(pos_g);
      acc2  <= quad4 ? IDX_W'(pos_g >> 1) : IDX_W'(pos_g);
    end else if (cmd.step_en) begin
      acc0 <= prod0 + add0[step];
      acc1 <= prod1 + add1[step];
      acc2 <= prod2 + add2[step];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.accept) begin
      step <= '0;
    end else if (cmd.step_en) begin
      step <= step + 1'b1;
    end
  end

  // index selection into the result register
  logic [IDX_W-1:0] sel_src, sel_dst, unpacked;

  assign unpacked = transposed_source ? acc1 : acc0;

  always_comb begin
    priority if (optimized_layout) begin
      sel_src = pack_direction ? unpacked : acc2;
      sel_dst = pack_direction ? acc2 : unpacked;
    end else if (transposed_source) begin
      sel_src = pack_direction ? acc1 : acc0;
      sel_dst = pack_direction ? acc0 : acc1;
    end else begin
      sel_src = acc0;
      sel_dst = acc0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      src_index <= sel_src;
      dst_index <= sel_dst;
      last      <= llast;
    end
  end

endmodule
